FILE: hdl/sutherland_viscosity_unit_macros.svh
// assertion macros for the sutherland viscosity unit
`ifndef SUTHERLAND_VISCOSITY_UNIT_MACROS_SVH
`define SUTHERLAND_VISCOSITY_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SVU_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("svu same-cycle check failed");
`define SVU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("svu next-cycle check failed");
`else
`define SVU_ASSERT_SAME(label, ante, cons)
`define SVU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hdl/svu_pkg.sv
// shared widths, codes and constants of the sutherland viscosity unit
package svu_pkg;
	localparam int S_W = 18;
	localparam int TR_W = 20;
	localparam int MU_W = 24;
	localparam int T_W = 20;
	localparam int V_W = 26;
	localparam int IDX_W = 2;
	localparam int SUM_W = 21;
	localparam int PROD_W = 41;
	localparam int QUO_W = 61;
	localparam int ROOT_W = 31;
	localparam int MUL_LAT = 4;

	localparam logic [IDX_W-1:0] REG_S = 2'd0;
	localparam logic [IDX_W-1:0] REG_TREF = 2'd1;
	localparam logic [IDX_W-1:0] REG_MUREF = 2'd2;

	localparam logic [S_W-1:0] S_RESET = 18'd30720;
	localparam logic [TR_W-1:0] TREF_RESET = 20'd74534;
	localparam logic [MU_W-1:0] MUREF_RESET = 24'd1197343;
	localparam logic [V_W-1:0] VISC_MAX = {V_W{1'b1}};
endpackage

FILE: hdl/svu_delay.sv
// fixed-length data delay line with enable
module svu_delay import svu_pkg::*; #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] tap_s [N];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= d;
			for (int i = 1; i < N; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign q = tap_s[N-1];
endmodule

FILE: hdl/svu_div.sv
// pipelined restoring divider, one quotient bit per stage
module svu_div import svu_pkg::*; #(
	parameter int NW = QUO_W,
	parameter int DW = PROD_W
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo
);
	logic [DW-1:0] rem_s [NW];
	logic [NW-1:0] work_s [NW];
	logic [DW-1:0] d_s [NW];

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [DW-1:0] rem_in;
		logic [DW-1:0] d_in;
		logic [NW-1:0] w_in;
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic ge;
		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign w_in = num;
			assign d_in = den;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign w_in = work_s[i-1];
			assign d_in = d_s[i-1];
		end
		assign trial = {rem_in, w_in[NW-1]};
		assign ge = trial >= {1'b0, d_in};
		assign diff = trial - {1'b0, d_in};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				work_s[i] <= {w_in[NW-2:0], ge};
				d_s[i] <= d_in;
			end
		end
	end

	assign quo = work_s[NW-1];
endmodule

FILE: hdl/svu_sqrt.sv
// pipelined integer square root, one root bit per stage
module svu_sqrt import svu_pkg::*; #(
	parameter int RW = ROOT_W
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*RW-1:0] v,
	output logic [RW-1:0]   root
);
	logic [RW+1:0] rem_s [RW];
	logic [RW-1:0] root_s [RW];
	logic [2*RW-1:0] work_s [RW];

	for (genvar j = 0; j < RW; j++) begin : g_stage
		logic [RW+1:0] rem_in;
		logic [RW-1:0] root_in;
		logic [2*RW-1:0] w_in;
		logic [RW+3:0] remx;
		logic [RW+3:0] trial;
		logic [RW+3:0] diff;
		logic ge;
		if (j == 0) begin : g_first
			assign rem_in = '0;
			assign root_in = '0;
			assign w_in = v;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign root_in = root_s[j-1];
			assign w_in = work_s[j-1];
		end
		assign remx = {rem_in, w_in[2*RW-1:2*RW-2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge = remx >= trial;
		assign diff = remx - trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? diff[RW+1:0] : remx[RW+1:0];
				root_s[j] <= {root_in[RW-2:0], ge};
				work_s[j] <= {w_in[2*RW-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[RW-1];
endmodule

FILE: hdl/svu_mul.sv
// product chain y * root * mu_ref with saturation, four stages
module svu_mul import svu_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [QUO_W-1:0]  y,
	input  logic [ROOT_W-1:0] sq,
	input  logic [MU_W-1:0]   mu_ref,
	input  logic              zero_den,
	output logic [V_W-1:0]    visc,
	output logic              sat
);
	logic [61:0] p0_s1;
	logic [60:0] p1_s1;
	logic z_s1;
	logic [45:0] ys_s2;
	logic ovf_s2;
	logic z_s2;
	logic [46:0] m0_s3;
	logic [46:0] m1_s3;
	logic ovf_s3;
	logic z_s3;
	logic [91:0] full;
	logic [69:0] prod;
	logic hit;

	assign full = {30'd0, p0_s1} + {p1_s1, 31'd0};
	assign prod = {23'd0, m0_s3} + {m1_s3, 23'd0};
	assign hit = z_s3 || (ovf_s3 && (mu_ref != '0)) || (prod[69:46] != '0);

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1 <= 62'(y[30:0] * sq);
			p1_s1 <= 61'(y[60:31] * sq);
			z_s1 <= zero_den;
			ys_s2 <= full[65:20];
			ovf_s2 <= full[91:66] != '0;
			z_s2 <= z_s1;
			m0_s3 <= 47'(mu_ref * ys_s2[22:0]);
			m1_s3 <= 47'(mu_ref * ys_s2[45:23]);
			ovf_s3 <= ovf_s2;
			z_s3 <= z_s2;
			visc <= hit ? VISC_MAX : prod[45:20];
			sat <= hit;
		end
	end
endmodule

FILE: hdl/sutherland_viscosity_unit.sv
// top level of the sutherland viscosity unit
// Temperature beats (unsigned Q12.8 K) enter on temperature_valid and
// leave temperature_stall low to be taken. Each beat yields one result
// beat of viscosity (unsigned Q10.16 uPa.s) with the saturated flag, on
// viscosity_valid, held while viscosity_stall is high.
// The pipeline has one entry stage forming the products, 61 stages
// of the quotient divider, 31 stages of the square root, and 4 stages
// of the multiply and saturate chain. One beat is taken every cycle
// unless the result beat is stalled; then the whole pipeline holds and
// temperature_stall rises; nothing is lost or repeated.
// The cfg port takes S, T_ref and mu_ref by index 0, 1 and 2 and is
// always ready; the user must make writes only while the pipeline is empty (unchecked).
// Reset clears all valid bits and loads the air constants.
module sutherland_viscosity_unit import svu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             temperature_valid,
	output logic             temperature_stall,
	input  logic [T_W-1:0]   temperature,
	output logic             viscosity_valid,
	input  logic             viscosity_stall,
	output logic [V_W-1:0]   viscosity,
	output logic             saturated,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [MU_W-1:0]  cfg_data
);
	`include "sutherland_viscosity_unit_macros.svh"

	localparam int LAT = 1 + QUO_W + ROOT_W + MUL_LAT;

	logic [S_W-1:0] s_q;
	logic [TR_W-1:0] tref_q;
	logic [MU_W-1:0] muref_q;
	logic [LAT-1:0] vld_s;
	logic en;
	logic [SUM_W-1:0] tsum;
	logic [SUM_W-1:0] rsum;
	logic [PROD_W-1:0] num_s1;
	logic [PROD_W-1:0] den_s1;
	logic [T_W-1:0] t_s1;
	logic z_s1;
	logic [QUO_W-1:0] y_div;
	logic [QUO_W-1:0] r_div;
	logic [QUO_W-1:0] y_dly;
	logic [ROOT_W-1:0] sq;
	logic z_dly;

	assign cfg_ready = 1'b1;
	assign en = !(vld_s[LAT-1] && viscosity_stall);
	assign temperature_stall = !en;
	assign viscosity_valid = vld_s[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q <= S_RESET;
			tref_q <= TREF_RESET;
			muref_q <= MUREF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_S: s_q <= cfg_data[S_W-1:0];
				REG_TREF: tref_q <= cfg_data[TR_W-1:0];
				REG_MUREF: muref_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], temperature_valid};
		end
	end

	assign tsum = SUM_W'(temperature) + SUM_W'(s_q);
	assign rsum = SUM_W'(tref_q) + SUM_W'(s_q);

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= PROD_W'(temperature * rsum);
			den_s1 <= PROD_W'(tref_q * tsum);
			t_s1 <= temperature;
			z_s1 <= (tref_q == '0) || (tsum == '0);
		end
	end

	svu_div #(.NW(QUO_W), .DW(PROD_W)) u_div_y (
		.clk(clk), .en(en), .num({num_s1, 20'd0}), .den(den_s1), .quo(y_div)
	);

	svu_div #(.NW(QUO_W), .DW(TR_W)) u_div_r (
		.clk(clk), .en(en), .num({1'b0, t_s1, 40'd0}), .den(tref_q), .quo(r_div)
	);

	svu_sqrt #(.RW(ROOT_W)) u_sqrt (
		.clk(clk), .en(en), .v({1'b0, r_div}), .root(sq)
	);

	svu_delay #(.W(QUO_W), .N(ROOT_W)) u_dly_y (
		.clk(clk), .en(en), .d(y_div), .q(y_dly)
	);

	svu_delay #(.W(1), .N(QUO_W + ROOT_W)) u_dly_z (
		.clk(clk), .en(en), .d(z_s1), .q(z_dly)
	);

	svu_mul u_mul (
		.clk(clk), .en(en), .y(y_dly), .sq(sq), .mu_ref(muref_q),
		.zero_den(z_dly), .visc(viscosity), .sat(saturated)
	);

	`SVU_ASSERT_NEXT(a_enter, temperature_valid && !temperature_stall, vld_s[0])
	`SVU_ASSERT_SAME(a_hold, viscosity_valid && viscosity_stall, temperature_stall)
	`SVU_ASSERT_SAME(a_sat_max, viscosity_valid && saturated, viscosity == VISC_MAX)
endmodule

FILE: dv/sutherland_viscosity_unit_tb.sv
// self-checking testbench for the sutherland viscosity unit: directed and random temperatures
module sutherland_viscosity_unit_tb import svu_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_LAT = 97;
	localparam int QUIET_CYCLES = PIPE_LAT + 20;
	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum logic {BEAT_TEMP, BEAT_CFG} beat_kind_t;

	typedef struct {
		beat_kind_t       kind;
		logic [IDX_W-1:0] index;
		logic [MU_W-1:0]  data;
		logic [T_W-1:0]   temp;
		int               send_idle;
		int               stall_pct;
	} beat_t;

	typedef struct {
		logic [V_W-1:0] viscosity;
		logic           saturated;
	} visc_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic temperature_valid = 1'b0;
	logic temperature_stall;
	logic [T_W-1:0] temperature = '0;
	logic viscosity_valid;
	logic viscosity_stall = 1'b0;
	logic [V_W-1:0] viscosity;
	logic saturated;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [MU_W-1:0] cfg_data = '0;

	beat_t pending_beats[$];
	visc_result_t expected_visc[$];
	logic [63:0] gas_s = S_RESET;
	logic [63:0] gas_tref = TREF_RESET;
	logic [63:0] gas_muref = MUREF_RESET;
	bit temp_taken = 1'b0;
	bit cfg_taken = 1'b0;
	int drained_cycles = 0;
	int stall_pct = 0;
	int send_idle = 0;
	bit failed = 1'b0;

	sutherland_viscosity_unit dut (.*);

	always #1 clk = ~clk;

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = '0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic visc_result_t predict_viscosity(logic [T_W-1:0] t_in);
		visc_result_t res;
		logic [63:0] t;
		logic [63:0] den;
		logic [63:0] y;
		logic [63:0] sq;
		logic [63:0] ys;
		logic [127:0] p;
		t = 64'(t_in);
		den = gas_tref * (t + gas_s);
		res.viscosity = VISC_MAX;
		res.saturated = 1'b1;
		if (den != 0) begin
			y = ((t * (gas_tref + gas_s)) << 20) / den;
			sq = int_sqrt((t << 40) / gas_tref);
			p = (128'(y) * 128'(sq)) >> 20;
			ys = (p[127:64] != 0) ? {64{1'b1}} : p[63:0];
			p = (128'(gas_muref) * 128'(ys)) >> 20;
			if (p <= 128'(VISC_MAX)) begin
				res.viscosity = p[V_W-1:0];
				res.saturated = 1'b0;
			end
		end
		return res;
	endfunction

	// driver
	always @(negedge clk) begin
		beat_t b;
		logic nxt_tv;
		logic nxt_cv;
		nxt_tv = temperature_valid;
		nxt_cv = cfg_valid;
		if (arst_n) begin
			viscosity_stall <= ($urandom_range(99) < stall_pct);
			if (!(temperature_valid && !temp_taken) && !(cfg_valid && !cfg_taken)) begin
				nxt_tv = 1'b0;
				nxt_cv = 1'b0;
				if (pending_beats.size() != 0) begin
					b = pending_beats[0];
					if (b.kind == BEAT_CFG) begin
						if (expected_visc.size() == 0 && drained_cycles >= QUIET_CYCLES) begin
							nxt_cv = 1'b1;
							cfg_index <= b.index;
							cfg_data <= b.data;
							void'(pending_beats.pop_front());
						end
					end else if ($urandom_range(99) >= b.send_idle) begin
						nxt_tv = 1'b1;
						temperature <= b.temp;
						stall_pct = b.stall_pct;
						void'(pending_beats.pop_front());
					end
				end
			end
		end
		temperature_valid <= nxt_tv;
		cfg_valid <= nxt_cv;
	end

	// monitor and predictor
	always @(posedge clk) begin
		visc_result_t exp_r;
		temp_taken = temperature_valid && !temperature_stall;
		cfg_taken = cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_taken) begin
				case (cfg_index)
					REG_S: gas_s = 64'(cfg_data[S_W-1:0]);
					REG_TREF: gas_tref = 64'(cfg_data[TR_W-1:0]);
					REG_MUREF: gas_muref = 64'(cfg_data);
					default: ;
				endcase
			end
			if (temp_taken)
				expected_visc.push_back(predict_viscosity(temperature));
			if (viscosity_valid && !viscosity_stall) begin
				if (expected_visc.size() == 0) begin
					$error("viscosity beat with no expectation: viscosity %0d saturated %0d",
						viscosity, saturated);
					failed = 1'b1;
				end else begin
					exp_r = expected_visc.pop_front();
					if (viscosity !== exp_r.viscosity) begin
						$error("viscosity: expected %0d actual %0d", exp_r.viscosity, viscosity);
						failed = 1'b1;
					end
					if (saturated !== exp_r.saturated) begin
						$error("saturated: expected %0d actual %0d", exp_r.saturated, saturated);
						failed = 1'b1;
					end
				end
			end
			drained_cycles = (expected_visc.size() == 0) ? drained_cycles + 1 : 0;
		end
	end

	task automatic add_temp(logic [T_W-1:0] t);
		beat_t b;
		b.kind = BEAT_TEMP;
		b.index = '0;
		b.data = '0;
		b.temp = t;
		b.send_idle = send_idle;
		b.stall_pct = stall_pct;
		pending_beats.push_back(b);
	endtask

	task automatic add_cfg(logic [IDX_W-1:0] idx, logic [MU_W-1:0] data);
		beat_t b;
		b.kind = BEAT_CFG;
		b.index = idx;
		b.data = data;
		b.temp = '0;
		b.send_idle = 0;
		b.stall_pct = 0;
		pending_beats.push_back(b);
	endtask

	function automatic logic [MU_W-1:0] pick_reg_value();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return MU_W'($urandom_range(1, 255));
			default: return MU_W'($urandom);
		endcase
	endfunction

	function automatic logic [63:0] gas_tref_hint();
		return 64'(TREF_RESET) - 1024;
	endfunction

	function automatic logic [T_W-1:0] pick_temp();
		case ($urandom_range(4))
			0: return T_W'($urandom_range(0, 4095));
			1: return T_W'($urandom_range(25600, 153600));
			2: return T_W'(gas_tref_hint() + $urandom_range(0, 2048));
			default: return T_W'($urandom);
		endcase
	endfunction

	initial begin
		int phase;
		int n;
		stall_pct = 56;
		send_idle = 11;
		// reset air constants
		add_temp('0);
		add_temp(20'd1);
		add_temp('1);
		add_temp(TREF_RESET);
		add_temp(20'h80000);
		add_temp(20'h55555);
		add_temp(20'h2AAAA);
		// zero sutherland constant: zero temperature gives zero denominator
		add_cfg(REG_S, '0);
		add_temp('0);
		add_temp(20'd1);
		add_temp('1);
		// zero reference temperature through masked upper bits
		add_cfg(REG_TREF, 24'hF00000);
		add_temp(20'd300);
		add_temp('0);
		// extreme constants and temperatures, some of which overflow the output
		add_cfg(REG_TREF, 24'd1);
		add_cfg(REG_S, '1);
		add_cfg(REG_MUREF, '1);
		add_cfg(REG_UNUSED, 24'h5A5A5A);
		add_temp('1);
		add_temp(20'd1);
		add_temp('0);
		add_cfg(REG_TREF, '1);
		add_temp(20'd1);
		add_temp('1);
		add_cfg(REG_MUREF, '0);
		add_temp(20'd77777);
		for (phase = 0; phase < 6; phase++) begin
			stall_pct = (phase < 2) ? 56 : (phase < 4) ? 11 : 0;
			send_idle = (phase < 2) ? 11 : (phase < 4) ? 56 : 0;
			if (phase == 0) begin
				add_cfg(REG_S, S_RESET);
				add_cfg(REG_TREF, TREF_RESET);
				add_cfg(REG_MUREF, MUREF_RESET);
			end else begin
				add_cfg(REG_S, pick_reg_value());
				add_cfg(REG_TREF, ($urandom_range(3) == 0) ? pick_reg_value()
					: MU_W'($urandom_range(1, 1048575)));
				add_cfg(REG_MUREF, pick_reg_value());
				if ($urandom_range(3) == 0)
					add_cfg(REG_UNUSED, MU_W'($urandom));
			end
			for (n = 0; n < 155; n++)
				add_temp(pick_temp());
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pending_beats.size() != 0 || temperature_valid || cfg_valid
			|| expected_visc.size() != 0)
			@(negedge clk);
		repeat (PIPE_LAT + 20) @(posedge clk);
		if (!failed && expected_visc.size() == 0)
			$display("sutherland_viscosity_unit_tb: PASS");
		else
			$display("sutherland_viscosity_unit_tb: FAIL");
		$finish;
	end

	initial begin
		#400000;
		$display("sutherland_viscosity_unit_tb: FAIL");
		$finish;
	end
endmodule

FILE: files.f
+incdir+hdl
hdl/svu_pkg.sv
hdl/svu_delay.sv
hdl/svu_div.sv
hdl/svu_sqrt.sv
hdl/svu_mul.sv
hdl/sutherland_viscosity_unit.sv
dv/sutherland_viscosity_unit_tb.sv
